/* sv/isre_pkg.sv */
// ----------------------------------------------------------------------------
// isre_pkg
// Shared types and constants for the index stream restart/expand block.
// ----------------------------------------------------------------------------
package isre_pkg;

  localparam int INDEX_BITS = 32;
  localparam logic [31:0] WIDE_MASK = 32'((64'd1 << INDEX_BITS) - 64'd1);
  localparam logic [31:0] NARROW_MASK = 32'h0000_ffff;

  localparam int CMD_DEPTH = 4;
  localparam int PTR_W     = $clog2(CMD_DEPTH);
  localparam int CNT_W     = $clog2(CMD_DEPTH + 1);

  // draw modes
  localparam logic [3:0] MODE_POINTS     = 4'd0;
  localparam logic [3:0] MODE_LINES      = 4'd1;
  localparam logic [3:0] MODE_LINE_LOOP  = 4'd2;
  localparam logic [3:0] MODE_LINE_STRIP = 4'd3;
  localparam logic [3:0] MODE_TRIANGLES  = 4'd4;
  localparam logic [3:0] MODE_TRI_STRIP  = 4'd5;
  localparam logic [3:0] MODE_FAN        = 4'd6;
  localparam logic [3:0] MODE_QUADS      = 4'd7;
  localparam logic [3:0] MODE_QUAD_STRIP = 4'd8;
  localparam logic [3:0] MODE_POLYGON    = 4'd9;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTART_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTART_VALUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPAND_ENABLE  = 3'd4;

  typedef struct packed {
    logic [31:0] index_raw;
    logic        last_in_draw;
  } in_item_t;

  typedef struct packed {
    logic [31:0] index_out;
    logic        index_valid;
    logic        end_of_draw;
    logic [31:0] range_min;
    logic [31:0] range_max;
    logic [31:0] written_count;
  } out_item_t;

  // One classified source index: up to four distinct values, replayed by the
  // back end either in order or in the quad split pattern.
  typedef struct packed {
    logic [3:0][31:0] vals;
    logic [2:0]       num;
    logic             quad;
    logic             last;
    logic [31:0]      range_min;
    logic [31:0]      range_max;
    logic [31:0]      written_count;
  } cmd_t;

endpackage

/* sv/isre_front.sv */
// ----------------------------------------------------------------------------
// isre_front
// Config registers, byte swap, restart detection and primitive assembly.
// Turns each accepted source index into at most one command.
// ----------------------------------------------------------------------------
module isre_front import isre_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_push,
  input  in_item_t             in_data,
  input  logic                 cmd_full,
  output logic                 cmd_push,
  output cmd_t                 cmd_data
);

  logic        width_r;
  logic [3:0]  mode_r;
  logic        rst_en_r;
  logic [31:0] rst_val_r;
  logic        exp_en_r;

  logic [31:0] run_min_r, run_min_nxt;
  logic [31:0] run_max_r, run_max_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] first_r;
  logic        seen_first_r, seen_first_nxt;
  logic [31:0] anchor_r, anchor_nxt;
  logic        anchor_needed_r, anchor_needed_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic        prev_valid_r, prev_valid_nxt;
  logic [31:0] slots_r [CMD_DEPTH];
  logic [2:0]  fill_r, fill_nxt;

  logic        accept;
  logic [31:0] wm;
  logic [31:0] v;
  logic        last;
  logic        active;
  logic        is_rst;
  logic        expand;
  logic        disjoint;
  logic        fan_mode;
  logic        quad_mode;
  logic [31:0] close_val;
  logic        track_en;
  logic        slot_we;
  logic [2:0]  cnt_add;
  logic [32:0] total_sum;
  logic [31:0] min_new, max_new, total_new;
  cmd_t        cmd;

  assign accept = in_push && !cmd_full;
  assign last   = in_data.last_in_draw;
  assign wm     = width_r ? WIDE_MASK : NARROW_MASK;

  always_comb begin
    if (width_r) begin
      v = {in_data.index_raw[7:0], in_data.index_raw[15:8],
           in_data.index_raw[23:16], in_data.index_raw[31:24]} & WIDE_MASK;
    end else begin
      v = {16'h0000, in_data.index_raw[7:0], in_data.index_raw[15:8]};
    end
  end

  // a 16-bit draw can never hit a restart value above 16 bits
  assign active = rst_en_r && (width_r || (rst_val_r[31:16] == 16'h0000));
  assign is_rst = active && (v == rst_val_r);

  assign expand = exp_en_r && ((mode_r == MODE_LINE_LOOP) || (mode_r == MODE_FAN) ||
                               (mode_r == MODE_QUADS) || (mode_r == MODE_POLYGON));
  assign disjoint = !((mode_r == MODE_LINE_LOOP) || (mode_r == MODE_LINE_STRIP) ||
                      (mode_r == MODE_TRI_STRIP) || (mode_r == MODE_FAN) ||
                      (mode_r == MODE_QUAD_STRIP) || (mode_r == MODE_POLYGON));
  assign fan_mode  = expand && ((mode_r == MODE_FAN) || (mode_r == MODE_POLYGON));
  assign quad_mode = expand && (mode_r == MODE_QUADS);
  assign close_val = seen_first_r ? first_r : v;

  always_comb begin
    anchor_nxt        = anchor_r;
    anchor_needed_nxt = anchor_needed_r;
    prev_nxt          = prev_r;
    prev_valid_nxt    = prev_valid_r;
    fill_nxt          = fill_r;
    track_en          = 1'b0;
    slot_we           = 1'b0;
    cnt_add           = 3'd0;
    cmd               = '0;

    if (fan_mode) begin
      if (anchor_needed_r) begin
        if (!is_rst) begin
          track_en          = 1'b1;
          anchor_nxt        = v;
          anchor_needed_nxt = 1'b0;
        end
      end else if (is_rst) begin
        anchor_needed_nxt = 1'b1;
        prev_valid_nxt    = 1'b0;
        prev_nxt          = '1;
      end else if (!prev_valid_r) begin
        track_en       = 1'b1;
        prev_nxt       = v;
        prev_valid_nxt = 1'b1;
      end else begin
        track_en    = 1'b1;
        cmd.vals[0] = anchor_r;
        cmd.vals[1] = prev_r;
        cmd.vals[2] = v;
        cmd.num     = 3'd3;
        cnt_add     = 3'd3;
        prev_nxt    = v;
      end
    end else if (quad_mode) begin
      if (is_rst) begin
        fill_nxt = 3'd0;
      end else begin
        track_en = 1'b1;
        slot_we  = 1'b1;
        if (fill_r == 3'd3) begin
          // fourth corner arrives now, so it comes straight from the input
          cmd.vals[0] = slots_r[0];
          cmd.vals[1] = slots_r[1];
          cmd.vals[2] = slots_r[2];
          cmd.vals[3] = v;
          cmd.num     = 3'd6;
          cmd.quad    = 1'b1;
          cnt_add     = 3'd6;
          fill_nxt    = 3'd0;
        end else begin
          fill_nxt = fill_r + 3'd1;
        end
      end
    end else begin
      if (!is_rst) begin
        track_en    = 1'b1;
        cmd.vals[0] = v;
        cmd.num     = 3'd1;
        cnt_add     = 3'd1;
      end else if (!disjoint) begin
        cmd.vals[0] = wm;
        cmd.num     = 3'd1;
        cnt_add     = 3'd1;
      end
      // line loop close, not counted
      if (expand && last) begin
        if (cmd.num == 3'd0) begin
          cmd.vals[0] = close_val;
        end else begin
          cmd.vals[1] = close_val;
        end
        cmd.num = cmd.num + 3'd1;
      end
    end

    min_new   = (track_en && (v < run_min_r)) ? v : run_min_r;
    max_new   = (track_en && (v > run_max_r)) ? v : run_max_r;
    total_sum = {1'b0, total_r} + 33'(cnt_add);
    total_new = total_sum[32] ? '1 : total_sum[31:0];

    cmd.last          = last;
    cmd.range_min     = min_new & wm;
    cmd.range_max     = max_new & wm;
    cmd.written_count = total_new;

    run_min_nxt    = min_new;
    run_max_nxt    = max_new;
    total_nxt      = total_new;
    seen_first_nxt = 1'b1;

    if (last) begin
      run_min_nxt       = '1;
      run_max_nxt       = '0;
      total_nxt         = '0;
      seen_first_nxt    = 1'b0;
      anchor_nxt        = '1;
      prev_nxt          = '1;
      anchor_needed_nxt = 1'b1;
      prev_valid_nxt    = 1'b0;
      fill_nxt          = 3'd0;
    end
  end

  assign cmd_push = accept && ((cmd.num != 3'd0) || last);
  assign cmd_data = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r         <= 1'b0;
      mode_r          <= MODE_POINTS;
      rst_en_r        <= 1'b0;
      rst_val_r       <= '1;
      exp_en_r        <= 1'b0;
      run_min_r       <= '1;
      run_max_r       <= '0;
      total_r         <= '0;
      seen_first_r    <= 1'b0;
      anchor_r        <= '1;
      anchor_needed_r <= 1'b1;
      prev_r          <= '1;
      prev_valid_r    <= 1'b0;
      fill_r          <= 3'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INDEX_WIDTH:    width_r   <= cfg_data[0];
          CFG_DRAW_MODE:      mode_r    <= cfg_data[3:0];
          CFG_RESTART_ENABLE: rst_en_r  <= cfg_data[0];
          CFG_RESTART_VALUE:  rst_val_r <= cfg_data;
          CFG_EXPAND_ENABLE:  exp_en_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        run_min_r       <= run_min_nxt;
        run_max_r       <= run_max_nxt;
        total_r         <= total_nxt;
        seen_first_r    <= seen_first_nxt;
        anchor_r        <= anchor_nxt;
        anchor_needed_r <= anchor_needed_nxt;
        prev_r          <= prev_nxt;
        prev_valid_r    <= prev_valid_nxt;
        fill_r          <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !seen_first_r) begin
      first_r <= v;
    end
    if (accept && slot_we) begin
      slots_r[fill_r[1:0]] <= v;
    end
  end

endmodule

/* sv/isre_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// isre_cmd_fifo
// Small command queue between the assembly front end and the emit back end.
// ----------------------------------------------------------------------------
module isre_cmd_fifo import isre_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t             mem_r [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(CMD_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/isre_back.sv */
// ----------------------------------------------------------------------------
// isre_back
// Replays each command as result beats into the output register, one per cycle
// while it is free or popped. Summary fields ride on the last beat of a draw.
// ----------------------------------------------------------------------------
module isre_back import isre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic [2:0] step_r, step_nxt;
  logic       load;
  logic       final_beat;
  logic [1:0] sel;

  // quad split order: 0 1 2 / 2 3 0
  function automatic logic [1:0] quad_sel(input logic [2:0] step);
    logic [1:0] s;
    case (step)
      3'd0:    s = 2'd0;
      3'd1:    s = 2'd1;
      3'd2:    s = 2'd2;
      3'd3:    s = 2'd2;
      3'd4:    s = 2'd3;
      3'd5:    s = 2'd0;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

  assign load       = !out_valid_r || out_pop;
  assign final_beat = (head.num == 3'd0) || (step_r == head.num - 3'd1);
  assign sel        = head.quad ? quad_sel(step_r) : step_r[1:0];
  assign cmd_pop    = load && !cmd_empty && final_beat;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    step_nxt      = step_r;
    if (load) begin
      out_valid_nxt = !cmd_empty;
      if (!cmd_empty) begin
        out_nxt = '0;
        if (head.num == 3'd0) begin
          out_nxt.end_of_draw = 1'b1;
        end else begin
          out_nxt.index_out   = head.vals[sel];
          out_nxt.index_valid = 1'b1;
          out_nxt.end_of_draw = head.last && final_beat;
        end
        if (out_nxt.end_of_draw) begin
          out_nxt.range_min     = head.range_min;
          out_nxt.range_max     = head.range_max;
          out_nxt.written_count = head.written_count;
        end
        step_nxt = final_beat ? 3'd0 : step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule

/* sv/index_stream_restart_expander.sv */
// ----------------------------------------------------------------------------
// index_stream_restart_expander
// Byte-swaps a draw's source indices, handles primitive restart, expands
// loops, fans, polygons and quads into lists, and reports min/max/count.
// ----------------------------------------------------------------------------
// Path: the first result beat of an item reaches out_data through the command
//   queue, then the output register.
// Throughput: one result beat per cycle unless a full output stalls; an item
//   gives 3 beats per fan/polygon triangle, 6 per full quad, 2 at a loop close.
// Reset: synchronous, active low; clears queue, output and per-draw state and
//   loads the configuration defaults. No clearing pass is needed.
module index_stream_restart_expander import isre_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_push,
  output logic                 in_full,
  input  in_item_t             in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_item_t            out_data
);

  logic cmd_push;
  cmd_t cmd_wdata;
  logic cmd_full;
  logic cmd_pop;
  cmd_t cmd_head;
  logic cmd_empty;

  assign in_full = cmd_full;

  isre_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_data   (in_data),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_wdata)
  );

  isre_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_wdata),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .head      (cmd_head),
    .empty     (cmd_empty)
  );

  isre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
